// File: hdl/archive_path_name_checker_unit_assert.svh
// Assertion macros for the archive path name checker.
`ifndef ARCHIVE_PATH_NAME_CHECKER_UNIT_ASSERT_SVH
`define ARCHIVE_PATH_NAME_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define APNC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define APNC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/apnc_pkg.sv
// Types and constants shared by the archive path name checker.
package apnc_pkg;

    localparam int MAX_NAME_DEF = 256;

    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_EMPTY     = 4'd1,
        ST_TOO_LONG  = 4'd2,
        ST_LEAD      = 4'd3,
        ST_TRAIL     = 4'd4,
        ST_NULL      = 4'd5,
        ST_EMPTY_SEG = 4'd6,
        ST_DOT       = 4'd7,
        ST_DOTDOT    = 4'd8,
        ST_ORDER     = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } seg_t;

    typedef enum logic [1:0] {
        ORD_EQUAL   = 2'd0,
        ORD_LESS    = 2'd1,
        ORD_GREATER = 2'd2
    } ord_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       is_last;
        logic       empty_name;
        logic       first_name;
    } in_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [8:0] name_len;
    } out_item_t;

endpackage

// File: hdl/apnc_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
module apnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // old contents come out when read and write hit the same entry
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/archive_path_name_checker_unit.sv
// Top level of the archive path name checker: byte pipeline around the name store.
//
//  channel  dir  handshake          payload
//  s_*      in   s_valid / s_ready  apnc_pkg::in_item_t  (one name byte)
//  m_*      out  m_valid / m_ready  apnc_pkg::out_item_t (status, length)
//
// One byte item per cycle, sustained while the output is not held. The status of a name
// passes through the stage register, loaded with the registered read of the previous-name
// store when its last item is accepted, and then through the output register.
// Reset (aresetn low, synchronous) clears the control state; the name store
// needs no clearing since only entries below the previous length are compared.
// A low m_ready with a result waiting holds the whole pipeline and s_ready.
`include "archive_path_name_checker_unit_assert.svh"

module archive_path_name_checker_unit #(
    parameter int MAX_NAME = apnc_pkg::MAX_NAME_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  apnc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output apnc_pkg::out_item_t m_data
);

    localparam int AW    = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int CNT_W = $clog2(MAX_NAME + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NAME);

    logic advance;
    logic s_fire;

    // stage 0: write address counter
    logic [CNT_W-1:0] wcount_reg, wcount_next;
    logic             in_range0;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    // stage 1: item with its index
    logic             v1_reg;
    apnc_pkg::in_item_t item1_reg;
    logic [CNT_W-1:0] idx1_reg;
    logic             inr1_reg;

    // per-name state
    logic [CNT_W-1:0] prev_len_reg, prev_len_next;
    apnc_pkg::seg_t    seg_reg, seg_next;
    apnc_pkg::status_t err_reg, err_next;
    apnc_pkg::ord_t    ord_reg, ord_next;
    logic             lead_reg, lead_next;
    logic             over_reg, over_next;

    logic             res_valid;
    apnc_pkg::status_t res_status;
    logic [CNT_W-1:0] cnt_after;
    logic [CNT_W+8:0] len_ext;

    logic             m_valid_reg;
    apnc_pkg::out_item_t m_data_reg;

    logic             end0;
    logic             end1;
    logic             out_empty;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign s_fire  = s_valid && advance;

    assign in_range0 = (wcount_reg < MAX_CNT);
    assign ram_we    = s_fire && !s_data.empty_name && in_range0;

    always_comb begin
        wcount_next = wcount_reg;
        if (s_fire) begin
            if (s_data.empty_name || s_data.is_last) begin
                wcount_next = '0;
            end else if (in_range0) begin
                wcount_next = CNT_W'(wcount_reg + 1'b1);
            end
        end
    end

    // read the stored byte for the comparison and overwrite it in the same cycle
    apnc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME)
    ) u_name_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wcount_reg[AW-1:0]),
        .wdata (s_data.name_byte),
        .re    (ram_we),
        .raddr (wcount_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcount_reg <= '0;
            v1_reg     <= 1'b0;
        end else begin
            wcount_reg <= wcount_next;
            if (advance) begin
                v1_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item1_reg <= s_data;
            idx1_reg  <= wcount_reg;
            inr1_reg  <= in_range0;
        end
    end

    // stage 1: segment, order and error tracking
    always_comb begin
        lead_next     = lead_reg;
        err_next      = err_reg;
        seg_next      = seg_reg;
        ord_next      = ord_reg;
        over_next     = over_reg;
        prev_len_next = prev_len_reg;
        res_valid     = 1'b0;
        res_status    = apnc_pkg::ST_OK;
        cnt_after     = inr1_reg ? CNT_W'(idx1_reg + 1'b1) : idx1_reg;

        if (item1_reg.empty_name) begin
            res_valid     = 1'b1;
            res_status    = apnc_pkg::ST_EMPTY;
            cnt_after     = '0;
            prev_len_next = '0;
            lead_next     = 1'b0;
            err_next      = apnc_pkg::ST_OK;
            seg_next      = apnc_pkg::SEG_EMPTY;
            ord_next      = apnc_pkg::ORD_EQUAL;
            over_next     = 1'b0;
        end else begin
            if (idx1_reg == '0 && item1_reg.name_byte == apnc_pkg::CH_SLASH) begin
                lead_next = 1'b1;
            end

            if (item1_reg.name_byte == apnc_pkg::CH_NUL) begin
                if (err_reg == apnc_pkg::ST_OK) begin
                    err_next = apnc_pkg::ST_NULL;
                end
            end else if (item1_reg.name_byte == apnc_pkg::CH_SLASH) begin
                if (err_reg == apnc_pkg::ST_OK) begin
                    case (seg_reg)
                        apnc_pkg::SEG_EMPTY:  err_next = apnc_pkg::ST_EMPTY_SEG;
                        apnc_pkg::SEG_DOT:    err_next = apnc_pkg::ST_DOT;
                        apnc_pkg::SEG_DOTDOT: err_next = apnc_pkg::ST_DOTDOT;
                        default:              err_next = err_reg;
                    endcase
                end
                seg_next = apnc_pkg::SEG_EMPTY;
            end else if (item1_reg.name_byte == apnc_pkg::CH_DOT) begin
                case (seg_reg)
                    apnc_pkg::SEG_EMPTY: seg_next = apnc_pkg::SEG_DOT;
                    apnc_pkg::SEG_DOT:   seg_next = apnc_pkg::SEG_DOTDOT;
                    default:             seg_next = apnc_pkg::SEG_OTHER;
                endcase
            end else begin
                seg_next = apnc_pkg::SEG_OTHER;
            end

            if (inr1_reg) begin
                if (ord_reg == apnc_pkg::ORD_EQUAL) begin
                    if (idx1_reg < prev_len_reg) begin
                        if (item1_reg.name_byte < ram_rdata) begin
                            ord_next = apnc_pkg::ORD_LESS;
                        end else if (item1_reg.name_byte > ram_rdata) begin
                            ord_next = apnc_pkg::ORD_GREATER;
                        end
                    end else begin
                        ord_next = apnc_pkg::ORD_GREATER;
                    end
                end
            end else begin
                over_next = 1'b1;
            end

            if (item1_reg.is_last) begin
                res_valid = 1'b1;
                if (over_next) begin
                    res_status = apnc_pkg::ST_TOO_LONG;
                end else if (lead_next) begin
                    res_status = apnc_pkg::ST_LEAD;
                end else if (item1_reg.name_byte == apnc_pkg::CH_SLASH) begin
                    res_status = apnc_pkg::ST_TRAIL;
                end else if (err_next != apnc_pkg::ST_OK) begin
                    res_status = err_next;
                end else if (seg_next == apnc_pkg::SEG_DOT) begin
                    res_status = apnc_pkg::ST_DOT;
                end else if (seg_next == apnc_pkg::SEG_DOTDOT) begin
                    res_status = apnc_pkg::ST_DOTDOT;
                end else if (!item1_reg.first_name && ord_next != apnc_pkg::ORD_GREATER) begin
                    res_status = apnc_pkg::ST_ORDER;
                end
                // start the next name fresh
                prev_len_next = cnt_after;
                lead_next     = 1'b0;
                err_next      = apnc_pkg::ST_OK;
                seg_next      = apnc_pkg::SEG_EMPTY;
                ord_next      = apnc_pkg::ORD_EQUAL;
                over_next     = 1'b0;
            end
        end
    end

    assign len_ext = {9'd0, cnt_after};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_len_reg <= '0;
            lead_reg     <= 1'b0;
            err_reg      <= apnc_pkg::ST_OK;
            seg_reg      <= apnc_pkg::SEG_EMPTY;
            ord_reg      <= apnc_pkg::ORD_EQUAL;
            over_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (advance && v1_reg) begin
                prev_len_reg <= prev_len_next;
                lead_reg     <= lead_next;
                err_reg      <= err_next;
                seg_reg      <= seg_next;
                ord_reg      <= ord_next;
                over_reg     <= over_next;
            end
            if (advance && v1_reg && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && v1_reg && res_valid) begin
            m_data_reg.status   <= res_status;
            m_data_reg.name_len <= len_ext[8:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign end0      = s_data.empty_name || s_data.is_last;
    assign end1      = item1_reg.empty_name || item1_reg.is_last;
    assign out_empty = m_valid_reg && (m_data_reg.status == apnc_pkg::ST_EMPTY);

    `APNC_ASSERT_NEXT(a_addr_clear, s_fire && end0, wcount_reg == '0, "count not cleared")
    `APNC_ASSERT_NOW(a_write_in_range, ram_we, wcount_reg < MAX_CNT, "store written past depth")
    `APNC_ASSERT_NEXT(a_result_loaded, advance && v1_reg && end1, m_valid_reg, "no result")
    `APNC_ASSERT_NOW(a_prev_len_bound, 1'b1, prev_len_reg <= MAX_CNT, "previous length too big")
    `APNC_ASSERT_NOW(a_empty_result, out_empty, m_data_reg.name_len == 9'd0, "empty with length")

endmodule
